FILE: hw/rtl/ufx_pkg.sv
// ----------------------------------------------------------------------------
// ufx_pkg: shared types and constants for the UART FIFO pair
// Depths, derived widths, reset values, item and register codes.
// ----------------------------------------------------------------------------
package ufx_pkg;

    localparam int RX_DEPTH = 256;
    localparam int TX_DEPTH = 256;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);

    localparam int BYTE_W  = 8;
    localparam int MARK_W  = 9;
    localparam int LEVEL_W = 9;
    localparam int CFG_IW  = 2;

    localparam int RX_CMP_W = (RX_CW > MARK_W) ? RX_CW : MARK_W;

    localparam logic [MARK_W-1:0] RST_HIGH_MARK = MARK_W'(150);
    localparam logic [MARK_W-1:0] RST_LOW_MARK  = MARK_W'(30);
    localparam logic [BYTE_W-1:0] RST_XON_CODE  = BYTE_W'(17);
    localparam logic [BYTE_W-1:0] RST_XOFF_CODE = BYTE_W'(19);

    localparam logic [CFG_IW-1:0] REG_HIGH_MARK = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_LOW_MARK  = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_XON_CODE  = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_XOFF_CODE = CFG_IW'(3);

    typedef enum logic [1:0] {
        MODE_LINE_RX = 2'd0,
        MODE_HOST_RD = 2'd1,
        MODE_HOST_WR = 2'd2,
        MODE_TX_RDY  = 2'd3
    } mode_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] wdata;
    } fifo_req_t;

endpackage

FILE: hw/rtl/ufx_rx_fifo.sv
// ----------------------------------------------------------------------------
// ufx_rx_fifo: receive FIFO
// Synchronous RAM with head pointer and count; read data one cycle after pop.
// ----------------------------------------------------------------------------
module ufx_rx_fifo
    import ufx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fifo_req_t         req,
    output logic [RX_CW-1:0]  count,
    output logic              full,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [RX_DEPTH];

    logic [RX_AW-1:0]  head_reg;
    logic [RX_AW-1:0]  head_next;
    logic [RX_CW-1:0]  count_reg;
    logic [RX_CW-1:0]  count_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic [RX_AW:0]    wsum;
    logic [RX_AW-1:0]  wptr;
    logic              push_ok;
    logic              pop_ok;

    assign full    = (count_reg == RX_CW'(RX_DEPTH));
    assign push_ok = req.push && !full;
    assign pop_ok  = req.pop && (count_reg != '0);

    assign wsum = (RX_AW + 1)'(head_reg) + (RX_AW + 1)'(count_reg);
    assign wptr = (wsum >= (RX_AW + 1)'(RX_DEPTH))
                  ? RX_AW'(wsum - (RX_AW + 1)'(RX_DEPTH)) : RX_AW'(wsum);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (pop_ok)
        begin
            head_next = (head_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wptr] <= req.wdata;
        end
        if (pop_ok)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign count = count_reg;
    assign rdata = rdata_reg;

`ifndef SYNTH
    a_rx_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RX_CW'(RX_DEPTH))
        else $error("rx count beyond depth");
`endif

endmodule

FILE: hw/rtl/ufx_tx_fifo.sv
// ----------------------------------------------------------------------------
// ufx_tx_fifo: transmit FIFO
// Synchronous RAM with head pointer and count. Entry zero reads as the
// reset XON code until it is first written.
// ----------------------------------------------------------------------------
module ufx_tx_fifo
    import ufx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fifo_req_t         req,
    output logic [TX_CW-1:0]  count,
    output logic              full,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [TX_DEPTH];

    logic [TX_AW-1:0]  head_reg;
    logic [TX_AW-1:0]  head_next;
    logic [TX_CW-1:0]  count_reg;
    logic [TX_CW-1:0]  count_next;
    logic              init_reg;
    logic              sub_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic [TX_AW:0]    wsum;
    logic [TX_AW-1:0]  wptr;
    logic              push_ok;
    logic              pop_ok;

    assign full    = (count_reg == TX_CW'(TX_DEPTH));
    assign push_ok = req.push && !full;
    assign pop_ok  = req.pop && (count_reg != '0);

    assign wsum = (TX_AW + 1)'(head_reg) + (TX_AW + 1)'(count_reg);
    assign wptr = (wsum >= (TX_AW + 1)'(TX_DEPTH))
                  ? TX_AW'(wsum - (TX_AW + 1)'(TX_DEPTH)) : TX_AW'(wsum);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (pop_ok)
        begin
            head_next = (head_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= TX_CW'(1);
            init_reg  <= 1'b1;
            sub_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (push_ok && (wptr == '0))
            begin
                init_reg <= 1'b0;
            end
            if (pop_ok)
            begin
                sub_reg <= init_reg && (head_reg == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wptr] <= req.wdata;
        end
        if (pop_ok)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign count = count_reg;
    assign rdata = sub_reg ? RST_XON_CODE : rdata_reg;

`ifndef SYNTH
    a_tx_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= TX_CW'(TX_DEPTH))
        else $error("tx count beyond depth");

    a_tx_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !init_reg |=> !init_reg)
        else $error("entry zero init flag set again");
`endif

endmodule

FILE: hw/rtl/uart_fifo_xon_xoff_flow_control_core.sv
// ----------------------------------------------------------------------------
// uart_fifo_xon_xoff_flow_control_core: UART FIFO pair with XON/XOFF control
// Receive and transmit FIFOs in RAM; host reads queue flow codes on the
// receive level crossing the marks.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   in       | in_valid / in_stall   | mode, data_in
//   out      | out_valid / out_stall | read_byte .. paused
//   cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The accept edge updates pointers, counts and flags, launches the RAM read
// and sets pend_reg, which loads the output register from the registered
// RAM data and stalls input. A waiting result holds off the next beat only
// while out_stall is high. No clearing pass after reset; transmit entry
// zero reads as the reset XON code until written. cfg_ready is always high.
// ----------------------------------------------------------------------------
module uart_fifo_xon_xoff_flow_control_core
    import ufx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [BYTE_W-1:0]  data_in,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [BYTE_W-1:0]  read_byte,
    output logic               read_valid,
    output logic [BYTE_W-1:0]  line_byte,
    output logic               line_valid,
    output logic               accepted,
    output logic [LEVEL_W-1:0] rx_level,
    output logic [LEVEL_W-1:0] tx_level,
    output logic               paused,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [MARK_W-1:0]  cfg_data
);

    logic [MARK_W-1:0] high_mark_reg;
    logic [MARK_W-1:0] low_mark_reg;
    logic [BYTE_W-1:0] xon_code_reg;
    logic [BYTE_W-1:0] xoff_code_reg;

    logic xon_flag_reg;
    logic xon_flag_next;
    logic xoff_flag_reg;
    logic xoff_flag_next;

    logic pend_reg;
    logic pacc_reg;
    logic prd_reg;
    logic pln_reg;
    logic pacc_next;
    logic prd_next;
    logic pln_next;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  read_byte_reg;
    logic               read_valid_reg;
    logic [BYTE_W-1:0]  line_byte_reg;
    logic               line_valid_reg;
    logic               accepted_reg;
    logic [LEVEL_W-1:0] rx_level_reg;
    logic [LEVEL_W-1:0] tx_level_reg;
    logic               paused_reg;

    fifo_req_t         rx_req;
    fifo_req_t         tx_req;
    logic [RX_CW-1:0]  rx_count;
    logic [TX_CW-1:0]  tx_count;
    logic              rx_full;
    logic              tx_full;
    logic [BYTE_W-1:0] rx_rdata;
    logic [BYTE_W-1:0] tx_rdata;

    logic  in_fire;
    logic  cfg_fire;
    logic  at_high;
    logic  at_low;
    mode_t mode_in;

    assign mode_in   = mode_t'(mode);
    assign in_stall  = pend_reg || (out_valid_reg && out_stall);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign at_high = RX_CMP_W'(rx_count) >= RX_CMP_W'(high_mark_reg);
    assign at_low  = RX_CMP_W'(rx_count) <= RX_CMP_W'(low_mark_reg);

    always_comb
    begin
        rx_req         = '0;
        tx_req         = '0;
        xon_flag_next  = xon_flag_reg;
        xoff_flag_next = xoff_flag_reg;
        pacc_next      = 1'b0;
        prd_next       = 1'b0;
        pln_next       = 1'b0;
        if (in_fire)
        begin
            case (mode_in)
                MODE_LINE_RX:
                begin
                    rx_req.push  = 1'b1;
                    rx_req.wdata = data_in;
                    pacc_next    = !rx_full;
                end
                MODE_HOST_RD:
                begin
                    if (at_high)
                    begin
                        if (xon_flag_reg)
                        begin
                            tx_req.push    = 1'b1;
                            tx_req.wdata   = xoff_code_reg;
                            xon_flag_next  = 1'b0;
                            xoff_flag_next = 1'b1;
                        end
                    end
                    else if (at_low)
                    begin
                        if (xoff_flag_reg)
                        begin
                            tx_req.push    = 1'b1;
                            tx_req.wdata   = xon_code_reg;
                            xoff_flag_next = 1'b0;
                            xon_flag_next  = 1'b1;
                        end
                    end
                    rx_req.pop = 1'b1;
                    prd_next   = (rx_count != '0);
                end
                MODE_HOST_WR:
                begin
                    tx_req.push  = 1'b1;
                    tx_req.wdata = data_in;
                    pacc_next    = !tx_full;
                end
                MODE_TX_RDY:
                begin
                    tx_req.pop = 1'b1;
                    pln_next   = (tx_count != '0);
                end
                default:
                begin
                    pacc_next = 1'b0;
                end
            endcase
        end
    end

    ufx_rx_fifo u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rx_req),
        .count (rx_count),
        .full  (rx_full),
        .rdata (rx_rdata)
    );

    ufx_tx_fifo u_tx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tx_req),
        .count (tx_count),
        .full  (tx_full),
        .rdata (tx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_mark_reg <= RST_HIGH_MARK;
            low_mark_reg  <= RST_LOW_MARK;
            xon_code_reg  <= RST_XON_CODE;
            xoff_code_reg <= RST_XOFF_CODE;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_HIGH_MARK: high_mark_reg <= cfg_data;
                REG_LOW_MARK:  low_mark_reg  <= cfg_data;
                REG_XON_CODE:  xon_code_reg  <= cfg_data[BYTE_W-1:0];
                REG_XOFF_CODE: xoff_code_reg <= cfg_data[BYTE_W-1:0];
                default:       high_mark_reg <= high_mark_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xon_flag_reg  <= 1'b1;
            xoff_flag_reg <= 1'b1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            xon_flag_reg  <= xon_flag_next;
            xoff_flag_reg <= xoff_flag_next;
            pend_reg      <= in_fire;
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pacc_reg <= pacc_next;
            prd_reg  <= prd_next;
            pln_reg  <= pln_next;
        end
        if (pend_reg)
        begin
            read_byte_reg  <= prd_reg ? rx_rdata : '0;
            read_valid_reg <= prd_reg;
            line_byte_reg  <= pln_reg ? tx_rdata : '0;
            line_valid_reg <= pln_reg;
            accepted_reg   <= pacc_reg;
            rx_level_reg   <= LEVEL_W'(rx_count);
            tx_level_reg   <= LEVEL_W'(tx_count);
            paused_reg     <= !xon_flag_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_byte  = read_byte_reg;
    assign read_valid = read_valid_reg;
    assign line_byte  = line_byte_reg;
    assign line_valid = line_valid_reg;
    assign accepted   = accepted_reg;
    assign rx_level   = rx_level_reg;
    assign tx_level   = tx_level_reg;
    assign paused     = paused_reg;

`ifndef SYNTH
    a_pend_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> out_valid_reg)
        else $error("pending beat did not reach output register");

    a_flags_not_both_clear: assert property (@(posedge clk) disable iff (!rst_n)
        xon_flag_reg || xoff_flag_reg)
        else $error("xon and xoff flags both clear");

    a_one_kind_of_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(read_valid_reg && (line_valid_reg || accepted_reg)))
        else $error("result carries more than one kind");

    a_single_flow_code: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (mode_in == MODE_HOST_RD) && tx_req.push
        |=> $changed({xon_flag_reg, xoff_flag_reg}))
        else $error("flow code queued without flag change");
`endif

endmodule
